>>> rtl/utf8sd_pkg.sv
// Package for the UTF-8 stream decoder.
// Holds the input and result word types, status codes and the lead byte decode.
// No dependencies.
package utf8sd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CP_W    = 21;
  localparam int unsigned LEN_W   = 3;
  localparam int unsigned IDX_W   = 16;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned REM_W   = 2;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_LEAD  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_TRUNCATED = 2'd2;

  localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
  localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
  localparam logic [LEN_W-1:0] LEN_MAX  = 3'd4;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              end_of_string;
  } in_word_t;

  typedef struct packed {
    logic [CP_W-1:0]   code_point;
    logic              char_done;
    logic [LEN_W-1:0]  seq_length;
    logic [IDX_W-1:0]  char_index;
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  char_count;
    logic              last;
  } out_word_t;

  typedef struct packed {
    logic [REM_W-1:0] bytes_remaining;
    logic [CP_W-1:0]  accumulator;
    logic [LEN_W-1:0] current_length;
    logic             error_latched;
  } seq_state_t;

  localparam seq_state_t SEQ_IDLE = '{default: '0};

  // Sequence length from a lead byte, LEN_NONE when the lead is invalid.
  function automatic logic [LEN_W-1:0] lead_length(input logic [BYTE_W-1:0] b);
    logic [LEN_W-1:0] n;
    begin
      if (b[7] == 1'b0) begin
        n = 3'd1;
      end else if (b[7:5] == 3'b110) begin
        n = 3'd2;
      end else if (b[7:4] == 4'b1110) begin
        n = 3'd3;
      end else if (b[7:3] == 5'b11110) begin
        n = 3'd4;
      end else begin
        n = LEN_NONE;
      end
      return n;
    end
  endfunction

  // Payload bits of a multi-byte lead.
  function automatic logic [CP_W-1:0] lead_bits(input logic [BYTE_W-1:0] b,
                                                input logic [LEN_W-1:0] n);
    logic [CP_W-1:0] v;
    begin
      case (n)
        3'd2:    v = {{(CP_W-5){1'b0}}, b[4:0]};
        3'd3:    v = {{(CP_W-4){1'b0}}, b[3:0]};
        3'd4:    v = {{(CP_W-3){1'b0}}, b[2:0]};
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

>>> rtl/utf8sd_step.sv
// Per-byte decode step of the UTF-8 stream decoder.
// Computes the next sequence state, character counter and result word.
// Depends on utf8sd_pkg.
module utf8sd_step #(
  parameter int unsigned INDEX_WIDTH = 16
) (
  input  utf8sd_pkg::in_word_t   word,
  input  utf8sd_pkg::seq_state_t state,
  input  logic [INDEX_WIDTH-1:0] chars_seen,
  output utf8sd_pkg::seq_state_t state_next,
  output logic [INDEX_WIDTH-1:0] chars_seen_next,
  output logic                   emit,
  output utf8sd_pkg::out_word_t  result
);
  import utf8sd_pkg::*;

  localparam logic [INDEX_WIDTH-1:0] CNT_MAX = {INDEX_WIDTH{1'b1}};

  logic [LEN_W-1:0]       n;
  logic                   done;
  logic [CP_W-1:0]        cp;
  logic [LEN_W-1:0]       len;
  seq_state_t             upd;
  logic [INDEX_WIDTH-1:0] cnt_after;
  logic [INDEX_WIDTH-1:0] idx;
  logic [IDX_W-1:0]       idx_out;
  logic [IDX_W-1:0]       cnt_out;
  logic [CP_W-1:0]        acc_shift;

  assign n         = lead_length(word.in_byte);
  assign acc_shift = {state.accumulator[CP_W-7:0], word.in_byte[5:0]};

  always_comb begin
    upd  = state;
    done = 1'b0;
    cp   = '0;
    len  = LEN_NONE;
    if (!state.error_latched) begin
      if (state.bytes_remaining == '0) begin
        if (n == LEN_NONE) begin
          upd.error_latched = 1'b1;
        end else if (n == LEN_ONE) begin
          done = 1'b1;
          cp   = {{(CP_W-BYTE_W){1'b0}}, word.in_byte};
          len  = LEN_ONE;
        end else begin
          upd.current_length  = n;
          upd.bytes_remaining = REM_W'(n - 3'd1);
          upd.accumulator     = lead_bits(word.in_byte, n);
        end
      end else begin
        upd.accumulator     = acc_shift;
        upd.bytes_remaining = state.bytes_remaining - 2'd1;
        if (state.bytes_remaining == 2'd1) begin
          done = 1'b1;
          cp   = acc_shift;
          len  = state.current_length;
        end
      end
    end
  end

  assign idx       = done ? chars_seen : '0;
  assign cnt_after = (done && chars_seen != CNT_MAX) ? chars_seen + 1'b1 : chars_seen;

  generate
    if (INDEX_WIDTH >= IDX_W) begin : g_wide
      assign idx_out = idx[IDX_W-1:0];
      assign cnt_out = cnt_after[IDX_W-1:0];
    end else begin : g_narrow
      assign idx_out = {{(IDX_W-INDEX_WIDTH){1'b0}}, idx};
      assign cnt_out = {{(IDX_W-INDEX_WIDTH){1'b0}}, cnt_after};
    end
  endgenerate

  always_comb begin
    result.code_point = cp;
    result.char_done  = done;
    result.seq_length = len;
    result.char_index = idx_out;
    result.last       = word.end_of_string;
    result.char_count = word.end_of_string ? cnt_out : '0;
    if (!word.end_of_string) begin
      result.status = STAT_OK;
    end else if (upd.error_latched) begin
      result.status = STAT_BAD_LEAD;
    end else if (upd.bytes_remaining != '0) begin
      result.status = STAT_TRUNCATED;
    end else begin
      result.status = STAT_OK;
    end
  end

  assign emit            = done || word.end_of_string;
  assign state_next      = word.end_of_string ? SEQ_IDLE : upd;
  assign chars_seen_next = word.end_of_string ? '0 : cnt_after;

endmodule

>>> rtl/utf8_stream_decoder_top.sv
// UTF-8 stream decoder, top level.
// Input register, decode step (utf8sd_step) and result register; uses utf8sd_pkg.
// Takes one byte per cycle while src_stall is low, each with an end-of-string
// flag, and returns a word for every byte that completes a character or ends a
// string: code point, byte length, character index, and on the final byte the
// character count and a status (invalid lead, truncated sequence). A new byte is
// taken every cycle unless the output stalls; each byte passes the input register,
// then the decode step and the result register, and the result word is held while
// dst_stall is high. Bytes that give no result are absorbed without an output word.
module utf8_stream_decoder_top #(
  parameter int unsigned INDEX_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  src_valid,
  output logic                  src_stall,
  input  utf8sd_pkg::in_word_t  src_word,
  output logic                  dst_valid,
  input  logic                  dst_stall,
  output utf8sd_pkg::out_word_t dst_word
);
  import utf8sd_pkg::*;

  in_word_t               src_reg;
  logic                   src_full;
  logic                   src_full_next;
  seq_state_t             state;
  seq_state_t             state_next;
  logic [INDEX_WIDTH-1:0] chars_seen;
  logic [INDEX_WIDTH-1:0] chars_seen_next;
  logic                   emit;
  out_word_t              result;
  logic                   dst_free;
  logic                   advance;
  logic                   take;

  assign dst_free  = !dst_valid || !dst_stall;
  assign advance   = src_full && dst_free;
  assign src_stall = src_full && !dst_free;
  assign take      = src_valid && !src_stall;

  always_comb begin
    src_full_next = src_full;
    if (take) begin
      src_full_next = 1'b1;
    end else if (advance) begin
      src_full_next = 1'b0;
    end
  end

  utf8sd_step #(
    .INDEX_WIDTH(INDEX_WIDTH)
  ) u_step (
    .word           (src_reg),
    .state          (state),
    .chars_seen     (chars_seen),
    .state_next     (state_next),
    .chars_seen_next(chars_seen_next),
    .emit           (emit),
    .result         (result)
  );

  always_ff @(posedge clk) begin
    if (take) begin
      src_reg <= src_word;
    end
    if (advance && emit) begin
      dst_word <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_full   <= 1'b0;
      dst_valid  <= 1'b0;
      state      <= SEQ_IDLE;
      chars_seen <= '0;
    end else begin
      src_full <= src_full_next;
      if (advance) begin
        state      <= state_next;
        chars_seen <= chars_seen_next;
      end
      if (advance && emit) begin
        dst_valid <= 1'b1;
      end else if (!dst_stall) begin
        dst_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_nochar_is_last: assert property (@(posedge clk) disable iff (rst)
    dst_valid && !dst_word.char_done |-> dst_word.last)
    else $error("result without a character is not the final word");

  a_mid_clean: assert property (@(posedge clk) disable iff (rst)
    dst_valid && !dst_word.last |-> dst_word.status == STAT_OK && dst_word.char_count == '0)
    else $error("status or count set on a word that is not the last");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_word.char_done |->
      dst_word.seq_length != LEN_NONE && dst_word.seq_length <= LEN_MAX)
    else $error("completed character with bad length");

  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    advance && src_reg.end_of_string |=> state == SEQ_IDLE && chars_seen == '0)
    else $error("string state not cleared after final byte");
`endif

endmodule
